// File: hdl/ura_pkg.sv
// ----------------------------------------------------------------------------
// ura_pkg
// Shared types and constants for the UART response line assembler.
// ----------------------------------------------------------------------------
package ura_pkg;

  // Line buffer sizing
  localparam int LINE_BYTES  = 64;
  localparam int STORE_DEPTH = 63;
  localparam int CNT_W       = 6;
  localparam int BANK_DEPTH  = 1 << CNT_W;
  localparam int RAM_DEPTH   = 2 * BANK_DEPTH;
  localparam int RAM_AW      = CNT_W + 1;

  // Characters stored per line before an overflow is declared
  localparam int STORE_LIMIT_I = (LINE_BYTES < 2) ? 1 :
                                 ((LINE_BYTES - 1 > STORE_DEPTH) ? STORE_DEPTH :
                                  LINE_BYTES - 1);
  localparam logic [CNT_W-1:0] STORE_LIMIT = CNT_W'(STORE_LIMIT_I);

  // Timeout register reset value
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // Characters of interest
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_HASH  = 8'h23;

  // Input event selector
  typedef enum logic [1:0] {
    FN_BYTE  = 2'd0,
    FN_TICK  = 2'd1,
    FN_ERROR = 2'd2
  } func_e;

  // Result status
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_UART_ERR = 2'd3
  } status_e;

  // Command passed from front to back
  typedef struct packed {
    logic             is_line;
    status_e          status;
    logic [CNT_W-1:0] len;
    logic             bank;
  } cmd_t;

  // Feedback from back to front
  typedef struct packed {
    logic line_done;
  } back_stat_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD,
    BK_SEND
  } back_state_e;

endpackage

// File: hdl/ura_in_if.sv
// ----------------------------------------------------------------------------
// ura_in_if
// Input event channel: event selector and received byte.
// ----------------------------------------------------------------------------
interface ura_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

// File: hdl/ura_out_if.sv
// ----------------------------------------------------------------------------
// ura_out_if
// Result channel: one line character or one status item per transaction.
// ----------------------------------------------------------------------------
interface ura_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_char, output char_valid, output status,
                  output last, input ready);
  modport sink   (input valid, input out_char, input char_valid, input status,
                  input last, output ready);
endinterface

// File: hdl/ura_cfg_if.sv
// ----------------------------------------------------------------------------
// ura_cfg_if
// Configuration write channel for the timeout register.
// ----------------------------------------------------------------------------
interface ura_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/ura_ram.sv
// ----------------------------------------------------------------------------
// ura_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ura_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// File: hdl/ura_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ura_cmd_fifo
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module ura_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ura_pkg::cmd_t   push_data_i,
  input  logic            pop_i,
  output ura_pkg::cmd_t   pop_data_o,
  output logic            full_o,
  output logic            empty_o
);

  ura_pkg::cmd_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i || pop_i;
  endproperty
  a_no_overflow: assert property (p_no_overflow)
    else $error("command queue written while full");

  property p_no_underflow;
    @(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i;
  endproperty
  a_no_underflow: assert property (p_no_underflow)
    else $error("command queue read while empty");

  property p_count_range;
    @(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3;
  endproperty
  a_count_range: assert property (p_count_range)
    else $error("command queue count out of range");

endmodule

// File: hdl/ura_front.sv
// ----------------------------------------------------------------------------
// ura_front
// Accepts events, tracks the current line and timeout, writes characters
// into the line buffer and queues line and status commands.
// ----------------------------------------------------------------------------
module ura_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ura_in_if.sink                       in_ch,
  ura_cfg_if.sink                      cfg_ch,
  output logic                         ram_wr_en_o,
  output logic [ura_pkg::RAM_AW-1:0]   ram_wr_addr_o,
  output logic [7:0]                   ram_wr_data_o,
  output logic                         push_o,
  output ura_pkg::cmd_t                push_data_o,
  input  logic                         fifo_full_i,
  input  ura_pkg::back_stat_t          back_stat_i
);

  logic [15:0]                timeout_q;
  logic [ura_pkg::CNT_W-1:0]  count_q, count_d;
  logic [15:0]                prev_q, prev_d;
  logic                       prompt_q, prompt_d;
  logic [15:0]                elapsed_q, elapsed_d;
  logic                       bank_q, bank_d;
  logic [1:0]                 busy_q, busy_d;
  logic                       accept;
  logic                       commit;
  logic [16:0]                elapsed_inc;
  logic [7:0]                 c;

  // command queue full or both buffer banks hold unread lines: hold off
  assign in_ch.ready  = !fifo_full_i && (busy_q < 2'd2);
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign c            = in_ch.rx_byte;
  assign elapsed_inc  = {1'b0, elapsed_q} + 17'd1;

  assign ram_wr_addr_o = {bank_q, count_q};
  assign ram_wr_data_o = c;

  // event classification
  always_comb begin
    count_d     = count_q;
    prev_d      = prev_q;
    prompt_d    = prompt_q;
    elapsed_d   = elapsed_q;
    bank_d      = bank_q;
    ram_wr_en_o = 1'b0;
    push_o      = 1'b0;
    commit      = 1'b0;
    push_data_o = '{is_line: 1'b0, status: ura_pkg::ST_OK, len: count_q, bank: bank_q};
    if (accept) begin
      unique case (in_ch.func)
        ura_pkg::FN_TICK: begin
          if (elapsed_inc >= {1'b0, timeout_q}) begin
            push_o             = 1'b1;
            push_data_o.status = ura_pkg::ST_TIMEOUT;
          end else begin
            elapsed_d = elapsed_inc[15:0];
          end
        end
        ura_pkg::FN_ERROR: begin
          push_o             = 1'b1;
          push_data_o.status = ura_pkg::ST_UART_ERR;
        end
        ura_pkg::FN_BYTE: begin
          if (c == ura_pkg::CH_LF) begin
            if (count_q != '0) begin
              if (prompt_q) begin
                count_d  = '0;
                prev_d   = '0;
                prompt_d = 1'b0;
              end else begin
                commit = 1'b1;
              end
            end
          end else if (c != ura_pkg::CH_CR) begin
            if (count_q >= ura_pkg::STORE_LIMIT) begin
              commit             = 1'b1;
              push_data_o.status = ura_pkg::ST_OVERFLOW;
            end else begin
              // prompt fragments: "~#" and "ASR"
              if (count_q >= 6'd1 && prev_q[7:0] == ura_pkg::CH_TILDE &&
                  c == ura_pkg::CH_HASH) begin
                prompt_d = 1'b1;
              end
              if (count_q >= 6'd2 && prev_q[15:8] == ura_pkg::CH_A &&
                  prev_q[7:0] == ura_pkg::CH_S && c == ura_pkg::CH_R) begin
                prompt_d = 1'b1;
              end
              ram_wr_en_o = 1'b1;
              count_d     = count_q + 6'd1;
              prev_d      = {prev_q[7:0], c};
            end
          end
        end
        default: begin
        end
      endcase
      if (commit) begin
        push_o              = 1'b1;
        push_data_o.is_line = 1'b1;
        bank_d              = ~bank_q;
      end
      // every result restarts the line and the timeout
      if (push_o) begin
        count_d   = '0;
        prev_d    = '0;
        prompt_d  = 1'b0;
        elapsed_d = '0;
      end
    end
  end

  // lines held in the buffer and not yet fully read
  always_comb begin
    case ({commit, back_stat_i.line_done})
      2'b10:   busy_d = busy_q + 2'd1;
      2'b01:   busy_d = busy_q - 2'd1;
      default: busy_d = busy_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ura_pkg::TIMEOUT_RESET;
      count_q   <= '0;
      prev_q    <= '0;
      prompt_q  <= 1'b0;
      elapsed_q <= '0;
      bank_q    <= 1'b0;
      busy_q    <= 2'd0;
    end else begin
      if (cfg_ch.valid) begin
        timeout_q <= cfg_ch.data;
      end
      count_q   <= count_d;
      prev_q    <= prev_d;
      prompt_q  <= prompt_d;
      elapsed_q <= elapsed_d;
      bank_q    <= bank_d;
      busy_q    <= busy_d;
    end
  end

  property p_busy_range;
    @(posedge clk_i) disable iff (!rst_ni) busy_q != 2'd3;
  endproperty
  a_busy_range: assert property (p_busy_range)
    else $error("more lines in flight than buffer banks");

  property p_write_in_range;
    @(posedge clk_i) disable iff (!rst_ni)
      ram_wr_en_o |-> count_q < ura_pkg::STORE_LIMIT;
  endproperty
  a_write_in_range: assert property (p_write_in_range)
    else $error("line buffer write beyond store limit");

  property p_commit_clears;
    @(posedge clk_i) disable iff (!rst_ni)
      push_o |=> count_q == '0 && elapsed_q == '0 && !prompt_q;
  endproperty
  a_commit_clears: assert property (p_commit_clears)
    else $error("line state not cleared after a result");

endmodule

// File: hdl/ura_back.sv
// ----------------------------------------------------------------------------
// ura_back
// Drains queued commands: reads stored lines one character at a time and
// presents characters and status items on the result channel.
// ----------------------------------------------------------------------------
module ura_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ura_pkg::cmd_t                cmd_i,
  input  logic                         cmd_empty_i,
  output logic                         cmd_pop_o,
  output logic                         ram_rd_en_o,
  output logic [ura_pkg::RAM_AW-1:0]   ram_rd_addr_o,
  input  logic [7:0]                   ram_rd_data_i,
  output ura_pkg::back_stat_t          back_stat_o,
  ura_out_if.source                    out_ch
);

  ura_pkg::back_state_e       state_q, state_d;
  ura_pkg::cmd_t              cmd_q, cmd_d;
  logic [ura_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic                       load_status, load_char;
  logic [7:0]                 char_q;
  logic                       char_valid_q;
  logic [1:0]                 status_q;
  logic                       last_q;

  assign ram_rd_addr_o = {cmd_q.bank, idx_q};
  assign out_ch.valid  = (state_q == ura_pkg::BK_SEND);
  assign out_ch.out_char   = char_q;
  assign out_ch.char_valid = char_valid_q;
  assign out_ch.status     = status_q;
  assign out_ch.last       = last_q;

  // sequencer
  always_comb begin
    state_d                = state_q;
    cmd_d                  = cmd_q;
    idx_d                  = idx_q;
    cmd_pop_o              = 1'b0;
    ram_rd_en_o            = 1'b0;
    load_status            = 1'b0;
    load_char              = 1'b0;
    back_stat_o.line_done  = 1'b0;
    unique case (state_q)
      ura_pkg::BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          if (cmd_i.is_line) begin
            state_d = ura_pkg::BK_READ;
          end else begin
            load_status = 1'b1;
            state_d     = ura_pkg::BK_SEND;
          end
        end
      end
      ura_pkg::BK_READ: begin
        ram_rd_en_o = 1'b1;
        state_d     = ura_pkg::BK_LOAD;
      end
      ura_pkg::BK_LOAD: begin
        load_char = 1'b1;
        state_d   = ura_pkg::BK_SEND;
      end
      ura_pkg::BK_SEND: begin
        if (out_ch.ready) begin
          if (cmd_q.is_line && !last_q) begin
            idx_d   = idx_q + 6'd1;
            state_d = ura_pkg::BK_READ;
          end else begin
            back_stat_o.line_done = cmd_q.is_line;
            state_d               = ura_pkg::BK_IDLE;
          end
        end
      end
      default: state_d = ura_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ura_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // command and output payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    if (load_status) begin
      char_q       <= 8'h00;
      char_valid_q <= 1'b0;
      status_q     <= cmd_i.status;
      last_q       <= 1'b1;
    end else if (load_char) begin
      char_q       <= ram_rd_data_i;
      char_valid_q <= 1'b1;
      status_q     <= cmd_q.status;
      last_q       <= (6'(idx_q + 6'd1) == cmd_q.len);
    end
  end

  property p_line_idx_range;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == ura_pkg::BK_READ) |-> idx_q < cmd_q.len;
  endproperty
  a_line_idx_range: assert property (p_line_idx_range)
    else $error("line read beyond its length");

  property p_done_on_send;
    @(posedge clk_i) disable iff (!rst_ni)
      back_stat_o.line_done |-> out_ch.valid && out_ch.ready && last_q;
  endproperty
  a_done_on_send: assert property (p_done_on_send)
    else $error("line released before its last character was taken");

  property p_pop_only_idle;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_pop_o |-> state_q == ura_pkg::BK_IDLE;
  endproperty
  a_pop_only_idle: assert property (p_pop_only_idle)
    else $error("command taken while busy");

endmodule

// File: hdl/uart_response_line_assembler.sv
// ----------------------------------------------------------------------------
// uart_response_line_assembler
// Frames CR/LF terminated text lines from a UART byte stream.
// ----------------------------------------------------------------------------
// Events (received byte, millisecond tick, UART error) are taken in one cycle
// each whenever the two-entry command queue has room and at most one finished
// line waits in the two-bank line buffer; a finished line is read back from the
// buffer by taking its command and then, per character, a RAM read, an output
// load and a transaction, plus any stall from the result side; a status item
// is sent once its command is taken.
// Lines containing "ASR" or "~#" are dropped, empty lines are skipped, and the
// timeout register bounds the ticks counted since the last result; it resets to 1000.
// ----------------------------------------------------------------------------
module uart_response_line_assembler (
  input  logic       clk_i,
  input  logic       rst_ni,
  ura_in_if.sink     in_ch,
  ura_cfg_if.sink    cfg_ch,
  ura_out_if.source  out_ch
);

  logic                         ram_wr_en;
  logic [ura_pkg::RAM_AW-1:0]   ram_wr_addr;
  logic [7:0]                   ram_wr_data;
  logic                         ram_rd_en;
  logic [ura_pkg::RAM_AW-1:0]   ram_rd_addr;
  logic [7:0]                   ram_rd_data;
  logic                         push;
  ura_pkg::cmd_t                push_data;
  logic                         pop;
  ura_pkg::cmd_t                pop_data;
  logic                         fifo_full;
  logic                         fifo_empty;
  ura_pkg::back_stat_t          back_stat;

  // event intake and line tracking
  ura_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .cfg_ch        (cfg_ch),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .push_o        (push),
    .push_data_o   (push_data),
    .fifo_full_i   (fifo_full),
    .back_stat_i   (back_stat)
  );

  // two-bank line buffer
  ura_ram #(
    .WIDTH (8),
    .DEPTH (ura_pkg::RAM_DEPTH)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // command queue
  ura_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  // result sequencing
  ura_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (pop_data),
    .cmd_empty_i   (fifo_empty),
    .cmd_pop_o     (pop),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .back_stat_o   (back_stat),
    .out_ch        (out_ch)
  );

endmodule
